// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/ffha_pkg.sv =====
package ffha_pkg;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_INIT  = 2'd2;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_NULL      = 3'd1;
  localparam logic [2:0] ST_UNINIT    = 3'd2;
  localparam logic [2:0] ST_EXHAUSTED = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;

  localparam logic CFG_HEAP_BASE = 1'b0;
  localparam logic CFG_HEAP_SIZE = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] request_size;
    logic [31:0] address;
  } in_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [2:0]  status;
    logic [31:0] free_bytes;
  } out_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] bytes;
    logic        is_free;
  } entry_t;

endpackage

// ===== src/first_fit_heap_allocator_unit.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | in_data  (ffha_pkg::in_t)
// out     | output    | out_valid / out_ready| out_data (ffha_pkg::out_t)
// cfg     | input     | cfg_we               | cfg_index, cfg_data
// One transaction at a time; the block table sits in one RAM with a registered read.
// Init and rejected requests go straight to the result. Allocate scans entries,
// moves entries on a split, then makes a free-byte recount pass over the blocks.
// Free scans entries, then makes a merge/recount pass. Sync reset empties the heap.
// A waiting result holds out_data; the next transaction can still be taken.
`include "assert_macros.svh"

module first_fit_heap_allocator_unit #(
  parameter int MAX_BLOCKS   = 256,
  parameter int HEADER_BYTES = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ffha_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ffha_pkg::out_t   out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [31:0] HB = 32'(HEADER_BYTES);
  localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SH_RD, S_SH_WR, S_SPLIT_WR,
    S_P_RD, S_P_PROC, S_DONE
  } state_t;

  state_t            st;
  logic [31:0]       heap_base;
  logic [31:0]       heap_size;
  logic [CW-1:0]     blk_count;
  logic [31:0]       free_total;
  logic              op_alloc;
  logic [32:0]       want;
  logic [31:0]       req_addr;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     hit;
  logic [CW-1:0]     wptr;
  ffha_pkg::entry_t  cur;
  ffha_pkg::entry_t  held;
  logic              held_valid;
  logic [31:0]       acc;
  logic [31:0]       res_addr;
  logic [2:0]        res_status;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  ffha_pkg::entry_t  ram_wdata;
  logic [IW-1:0]     ram_raddr;
  ffha_pkg::entry_t  ram_rdata;

  logic [31:0]       init_bytes;
  logic              fits;
  logic              can_split;
  ffha_pkg::entry_t  split_entry;
  ffha_pkg::entry_t  pe;
  logic [33:0]       merge_sum;
  logic [31:0]       merge_bytes;
  logic [32:0]       acc_sum;
  logic [31:0]       acc_next;
  logic              do_merge;
  logic              in_fire;

  ffha_ram #(.WIDTH($bits(ffha_pkg::entry_t)), .DEPTH(MAX_BLOCKS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (st == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    init_bytes = (heap_size >= HB) ? heap_size - HB : 32'd0;
    fits = ram_rdata.is_free && ({1'b0, ram_rdata.bytes} >= want);
    can_split = ({2'b0, ram_rdata.bytes} >= {1'b0, want} + 34'(HB) + 34'd4)
                && (blk_count < MAXC);
    split_entry.start   = cur.start + HB + want[31:0];
    split_entry.bytes   = cur.bytes - want[31:0] - HB;
    split_entry.is_free = 1'b1;
    pe = ram_rdata;
    if (!op_alloc && idx == hit) begin
      pe.is_free = 1'b1;
    end
    merge_sum = {2'b0, held.bytes} + 34'(HB) + {2'b0, pe.bytes};
    merge_bytes = (merge_sum[33:32] != 2'b0) ? 32'hFFFF_FFFF : merge_sum[31:0];
    acc_sum = {1'b0, acc} + {1'b0, held.bytes};
    acc_next = held.is_free ? (acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0]) : acc;
    do_merge = !op_alloc && held.is_free && pe.is_free;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[IW-1:0];
    ram_wdata = held;
    ram_raddr = idx[IW-1:0];
    unique case (st)
      S_IDLE: begin
        if (in_fire && in_data.kind == ffha_pkg::KIND_INIT) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = '{start: heap_base, bytes: init_bytes, is_free: 1'b1};
        end
      end
      S_SCAN_CHK: begin
        if (op_alloc && fits && !can_split) begin
          ram_we    = 1'b1;
          ram_wdata = '{start: ram_rdata.start, bytes: ram_rdata.bytes, is_free: 1'b0};
        end
      end
      S_SH_RD: begin
        ram_raddr = IW'(idx - CW'(1));
        if (idx == hit + CW'(1)) begin
          ram_we    = 1'b1;
          ram_wdata = split_entry;
        end
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_SPLIT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = hit[IW-1:0];
        ram_wdata = '{start: cur.start, bytes: want[31:0], is_free: 1'b0};
      end
      S_P_RD: begin
        if (idx == blk_count) begin
          ram_we    = 1'b1;
          ram_waddr = wptr[IW-1:0];
        end
      end
      S_P_PROC: begin
        if (held_valid && !do_merge) begin
          ram_we    = 1'b1;
          ram_waddr = wptr[IW-1:0];
        end
      end
      S_SCAN_RD, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      heap_base  <= 32'd0;
      heap_size  <= 32'd1048576;
      blk_count  <= '0;
      free_total <= 32'd0;
      out_valid  <= 1'b0;
      held_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == ffha_pkg::CFG_HEAP_BASE) begin
          heap_base <= cfg_data;
        end else begin
          heap_size <= cfg_data;
        end
      end
      if (out_valid && out_ready && st != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (in_fire) begin
            op_alloc   <= (in_data.kind == ffha_pkg::KIND_ALLOC);
            want       <= ({1'b0, in_data.request_size} + 33'd3) & ~33'd3;
            req_addr   <= in_data.address;
            idx        <= '0;
            res_addr   <= 32'd0;
            hit        <= '1;
            st         <= S_DONE;
            priority if (in_data.kind == ffha_pkg::KIND_INIT) begin
              blk_count  <= CW'(1);
              free_total <= init_bytes;
              res_status <= ffha_pkg::ST_DONE;
            end else if (in_data.kind != ffha_pkg::KIND_ALLOC &&
                         in_data.kind != ffha_pkg::KIND_FREE) begin
              res_status <= ffha_pkg::ST_NULL;
            end else if (blk_count == '0) begin
              res_status <= ffha_pkg::ST_UNINIT;
            end else if (in_data.kind == ffha_pkg::KIND_ALLOC &&
                         in_data.request_size == 32'd0) begin
              res_status <= ffha_pkg::ST_NULL;
            end else if (in_data.kind == ffha_pkg::KIND_FREE &&
                         in_data.address == 32'd0) begin
              res_status <= ffha_pkg::ST_NULL;
            end else begin
              st <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          if (idx == blk_count) begin
            res_status <= op_alloc ? ffha_pkg::ST_EXHAUSTED : ffha_pkg::ST_UNKNOWN;
            st         <= S_DONE;
          end else begin
            st <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          cur <= ram_rdata;
          if (op_alloc && fits) begin
            hit        <= idx;
            res_addr   <= ram_rdata.start + HB;
            res_status <= ffha_pkg::ST_DONE;
            if (can_split) begin
              idx <= blk_count;
              st  <= S_SH_RD;
            end else begin
              idx <= '0;
              st  <= S_P_RD;
            end
          end else if (!op_alloc && ram_rdata.start + HB == req_addr) begin
            hit        <= idx;
            res_status <= ffha_pkg::ST_DONE;
            idx        <= '0;
            st         <= S_P_RD;
          end else begin
            idx <= idx + CW'(1);
            st  <= S_SCAN_RD;
          end
        end
        S_SH_RD: begin
          st <= (idx == hit + CW'(1)) ? S_SPLIT_WR : S_SH_WR;
        end
        S_SH_WR: begin
          idx <= idx - CW'(1);
          st  <= S_SH_RD;
        end
        S_SPLIT_WR: begin
          blk_count <= blk_count + CW'(1);
          idx       <= '0;
          st        <= S_P_RD;
        end
        S_P_RD: begin
          if (idx == blk_count) begin
            blk_count  <= wptr + CW'(1);
            free_total <= acc_next;
            held_valid <= 1'b0;
            st         <= S_DONE;
          end else begin
            st <= S_P_PROC;
          end
          if (idx == '0) begin
            wptr       <= '0;
            acc        <= 32'd0;
            held_valid <= 1'b0;
          end
        end
        S_P_PROC: begin
          idx <= idx + CW'(1);
          st  <= S_P_RD;
          if (!held_valid) begin
            held       <= pe;
            held_valid <= 1'b1;
          end else if (do_merge) begin
            held.bytes <= merge_bytes;
          end else begin
            acc  <= acc_next;
            wptr <= wptr + CW'(1);
            held <= pe;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= '{result_address: res_addr, status: res_status,
                           free_bytes: free_total};
            st        <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_range, clk, rst, blk_count <= MAXC)
  `ASSERT_IMPLIES(a_walk_has_blocks, clk, rst, (st == S_SCAN_CHK || st == S_P_PROC), blk_count != '0)
  `ASSERT_IMPLIES(a_addr_only_on_done, clk, rst, out_valid && out_data.status != ffha_pkg::ST_DONE, out_data.result_address == 32'd0)
  `ASSERT_IMPLIES(a_split_has_room, clk, rst, st == S_SPLIT_WR, blk_count < MAXC)

endmodule

// ===== src/ffha_ram.sv =====
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
